>>> rtl/shp_pkg.sv
// Shared types and constants for the half-step stepper positioner.
// Item structs, command and register codes, and default sizing.
// No dependencies.
package shp_pkg;

    localparam int POSITION_BITS_DEF = 16;
    localparam int FIELD_POS_BITS    = 16;
    localparam int TABLE_BITS        = 64;
    localparam int CFG_INDEX_BITS    = 1;
    localparam int PHASE_BITS        = 3;

    localparam logic [PHASE_BITS-1:0] PHASE_LAST = 3'd7;
    localparam logic [PHASE_BITS-1:0] PHASE_FIRST = 3'd0;

    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_LOAD  = 2'd2;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_PHASE_TABLE = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_TEST_MODE   = 1'b1;

    typedef struct packed {
        logic [1:0]                command;
        logic [FIELD_POS_BITS-1:0] target_position;
        logic                      forward;
        logic [FIELD_POS_BITS-1:0] new_position;
    } cmd_item_t;

    typedef struct packed {
        logic [7:0]                coil_drive;
        logic [FIELD_POS_BITS-1:0] position;
        logic [PHASE_BITS-1:0]     phase_index;
        logic                      moving;
        logic                      arrived;
    } res_item_t;

    typedef struct packed {
        logic [TABLE_BITS-1:0] phase_table;
        logic                  test_mode;
    } cfg_t;

endpackage

>>> rtl/shp_core.sv
// Motion state of the positioner: phase, position, goal, run/arrived flags, coils.
// Updates once per fired item and presents the resulting item combinationally.
// Depends on shp_pkg.
module shp_core
    import shp_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      fire,
    input  cmd_item_t item,
    input  cfg_t      cfg,
    output res_item_t result
);

    logic [PHASE_BITS-1:0]    phase_reg,   phase_next;
    logic [POSITION_BITS-1:0] pos_reg,     pos_next;
    logic [POSITION_BITS-1:0] goal_reg,    goal_next;
    logic                     dir_reg,     dir_next;
    logic                     run_reg,     run_next;
    logic                     done_reg,    done_next;
    logic [7:0]               drive_reg,   drive_next;

    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        goal_next  = goal_reg;
        dir_next   = dir_reg;
        run_next   = run_reg;
        done_next  = done_reg;
        drive_next = drive_reg;
        case (item.command)
            CMD_TICK:
            begin
                if (run_reg)
                begin
                    if (pos_reg != goal_reg)
                    begin
                        drive_next = cfg.phase_table[{phase_reg, 3'b000} +: 8];
                        if (dir_reg)
                        begin
                            phase_next = (phase_reg == PHASE_LAST) ? PHASE_FIRST
                                                                   : phase_reg + 1'b1;
                            pos_next   = pos_reg + 1'b1;
                        end
                        else
                        begin
                            phase_next = (phase_reg == PHASE_FIRST) ? PHASE_LAST
                                                                    : phase_reg - 1'b1;
                            // reverse saturates at zero
                            if (pos_reg != '0)
                            begin
                                pos_next = pos_reg - 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        run_next   = 1'b0;
                        drive_next = '0;
                        done_next  = 1'b1;
                    end
                end
                else if (!cfg.test_mode)
                begin
                    drive_next = '0;
                    phase_next = PHASE_FIRST;
                end
            end
            CMD_START:
            begin
                goal_next = POSITION_BITS'(item.target_position);
                dir_next  = item.forward;
                run_next  = 1'b1;
                done_next = 1'b0;
            end
            CMD_LOAD:
            begin
                pos_next = POSITION_BITS'(item.new_position);
            end
            default:
            begin
                // unused code: report only
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
            pos_reg   <= '0;
            goal_reg  <= '0;
            dir_reg   <= 1'b0;
            run_reg   <= 1'b0;
            done_reg  <= 1'b0;
            drive_reg <= '0;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            goal_reg  <= goal_next;
            dir_reg   <= dir_next;
            run_reg   <= run_next;
            done_reg  <= done_next;
            drive_reg <= drive_next;
        end
    end

    assign result.coil_drive  = drive_next;
    assign result.position    = FIELD_POS_BITS'(pos_next);
    assign result.phase_index = phase_next;
    assign result.moving      = run_next;
    assign result.arrived     = done_next;

endmodule

>>> rtl/stepper_half_step_positioner_unit.sv
// Top level of the half-step stepper positioner.
// Input register, shp_core motion logic, result register, config registers.
// Depends on shp_pkg and shp_core.
//
// Usage:
//   Command items (tick, start move, load position) enter on cmd_valid/cmd_stall;
//   an item is taken on a clock edge with cmd_valid high and cmd_stall low.
//   Every command item yields exactly one result item on res_valid/res_stall,
//   taken on an edge with res_valid high and res_stall low.
//   Path: an accepted item passes the input register, then the result
//   register, where res_valid rises and the result can be taken.
//   Throughput: one item per clock while res_stall is low; the motion state
//   update is a single compare, increment/decrement and 8-way phase table byte select.
//   Receiver stall: the result register holds its item, the input register
//   fills, and cmd_stall rises once both are occupied. Nothing is dropped.
//   Configuration: cfg_write with cfg_index 0 loads the 64-bit phase table,
//   index 1 loads test mode from cfg_data[0]. Write only while no items are
//   in flight.
//   Reset (rst_n low, asynchronous): motion state, flags, coils and config
//   clear to zero; both pipeline stages empty.
module stepper_half_step_positioner_unit
    import shp_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cmd_valid,
    output logic                      cmd_stall,
    input  cmd_item_t                 cmd_item,
    output logic                      res_valid,
    input  logic                      res_stall,
    output res_item_t                 res_item,
    input  logic                      cfg_write,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [TABLE_BITS-1:0]     cfg_data
);

    cfg_t      cfg_reg;
    logic      s1_valid_reg;
    cmd_item_t s1_item_reg;
    logic      res_valid_reg;
    res_item_t res_item_reg;
    res_item_t core_result;
    logic      advance;
    logic      fire;

    // pipeline moves when the result slot is free or being drained
    assign advance   = !res_valid_reg || !res_stall;
    assign fire      = advance && s1_valid_reg;
    assign cmd_stall = s1_valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_PHASE_TABLE: cfg_reg.phase_table <= cfg_data;
                CFG_TEST_MODE:   cfg_reg.test_mode   <= cfg_data[0];
                default:         cfg_reg             <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            // an empty input stage takes an item even while the result waits
            if (!cmd_stall)
            begin
                s1_valid_reg <= cmd_valid;
            end
            if (advance)
            begin
                res_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!cmd_stall)
        begin
            s1_item_reg <= cmd_item;
        end
        if (fire)
        begin
            res_item_reg <= core_result;
        end
    end

    shp_core #(
        .POSITION_BITS (POSITION_BITS)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (s1_item_reg),
        .cfg    (cfg_reg),
        .result (core_result)
    );

    assign res_valid = res_valid_reg;
    assign res_item  = res_item_reg;

    // a move in progress and arrival are mutually exclusive
    a_moving_not_arrived: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> !(res_item_reg.moving && res_item_reg.arrived))
        else $error("moving and arrived both set");

    // a fired item always lands in the result register
    a_fire_lands: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> res_valid_reg)
        else $error("fired item lost");

    // input side stalls only when the input stage is occupied and blocked
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_stall |-> (s1_valid_reg && res_valid_reg && res_stall))
        else $error("input stalled without cause");

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for stepper_half_step_positioner_unit.
// Holds a motion predictor in a small class; plain tasks drive commands and config.
// Depends on shp_pkg and the RTL of the positioner.
module testbench
    import shp_pkg::*;
();

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 20;

    // Predicts one result per accepted command and checks results in order.
    class positioner_scoreboard;
        logic [TABLE_BITS-1:0]     coil_table;
        logic                      hold_when_idle;
        logic [PHASE_BITS-1:0]     phase;
        logic [FIELD_POS_BITS-1:0] pos;
        logic [FIELD_POS_BITS-1:0] goal;
        logic                      fwd;
        logic                      running;
        logic                      done;
        logic [7:0]                coils;
        res_item_t                 pending[$];
        int                        fails;

        function new();
            coil_table     = '0;
            hold_when_idle = 1'b0;
            phase          = PHASE_FIRST;
            pos            = '0;
            goal           = '0;
            fwd            = 1'b0;
            running        = 1'b0;
            done           = 1'b0;
            coils          = '0;
            fails          = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [TABLE_BITS-1:0] value);
            if (idx == CFG_PHASE_TABLE)
                coil_table = value;
            else if (idx == CFG_TEST_MODE)
                hold_when_idle = value[0];
        endfunction

        function void step_motor();
            if (running) begin
                if (pos != goal) begin
                    coils = coil_table[phase*8 +: 8];
                    if (fwd) begin
                        phase = (phase == PHASE_LAST) ? PHASE_FIRST : phase + 1'b1;
                        pos   = pos + 1'b1;
                    end
                    else begin
                        phase = (phase == PHASE_FIRST) ? PHASE_LAST : phase - 1'b1;
                        if (pos != '0)
                            pos = pos - 1'b1;
                    end
                end
                else begin
                    running = 1'b0;
                    coils   = '0;
                    done    = 1'b1;
                end
            end
            else if (!hold_when_idle) begin
                coils = '0;
                phase = PHASE_FIRST;
            end
        endfunction

        function void note_command(cmd_item_t c);
            res_item_t r;
            case (c.command)
                CMD_TICK:  step_motor();
                CMD_START:
                begin
                    goal    = c.target_position;
                    fwd     = c.forward;
                    running = 1'b1;
                    done    = 1'b0;
                end
                CMD_LOAD:  pos = c.new_position;
                default:   ;
            endcase
            r.coil_drive  = coils;
            r.position    = pos;
            r.phase_index = phase;
            r.moving      = running;
            r.arrived     = done;
            pending.push_back(r);
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            fails++;
        endtask

        task check_result(res_item_t got);
            res_item_t want;
            if (pending.size() == 0)
            begin
                report($sformatf("result %h with nothing expected", got));
                return;
            end
            want = pending.pop_front();
            if (got.coil_drive !== want.coil_drive)
                report($sformatf("coil_drive %h, expected %h", got.coil_drive, want.coil_drive));
            if (got.position !== want.position)
                report($sformatf("position %h, expected %h", got.position, want.position));
            if (got.phase_index !== want.phase_index)
                report($sformatf("phase_index %0d, expected %0d",
                                 got.phase_index, want.phase_index));
            if (got.moving !== want.moving)
                report($sformatf("moving %b, expected %b", got.moving, want.moving));
            if (got.arrived !== want.arrived)
                report($sformatf("arrived %b, expected %b", got.arrived, want.arrived));
        endtask
    endclass

    logic                      clk;
    logic                      rst_n = 1'b0;
    logic                      cmd_valid = 1'b0;
    logic                      cmd_stall;
    cmd_item_t                 cmd_item = '0;
    logic                      res_valid;
    logic                      res_stall = 1'b0;
    res_item_t                 res_item;
    logic                      cfg_write = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [TABLE_BITS-1:0]     cfg_data = '0;

    positioner_scoreboard motion = new();

    int  cycles = 0;
    int  burst_left = 0;
    bit  sender_gaps = 1'b1;
    int  items_issued = 0;
    // toggled to ask the receiver for a long hold-off
    logic hold_toggle = 1'b0;

    stepper_half_step_positioner_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_item  (cmd_item),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_item  (res_item),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("stepper_half_step_positioner_unit test failed");
        $finish;
    end

    // Receiver: checks taken items, stalls in changing styles plus requested hold-offs.
    initial
    begin
        int   style;
        int   rcv_cycle;
        int   hold_left;
        logic seen_toggle;
        style       = 0;
        rcv_cycle   = 0;
        hold_left   = 0;
        seen_toggle = 1'b0;
        forever
        begin
            @(posedge clk);
            if (res_valid && !res_stall)
                motion.check_result(res_item);
            rcv_cycle++;
            if (rcv_cycle % 50 == 0)
                style = $urandom_range(0, 3);
            if (hold_toggle != seen_toggle)
            begin
                seen_toggle = hold_toggle;
                hold_left   = 90;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_stall <= 1'b1;
            end
            else
            begin
                case (style)
                    0:       res_stall <= 1'b0;
                    1:       res_stall <= ($urandom_range(0, 99) < 30);
                    2:       res_stall <= ($urandom_range(0, 99) < 75);
                    default: res_stall <= (rcv_cycle % 3 == 0);
                endcase
            end
        end
    end

    function automatic cmd_item_t make_cmd(logic [1:0] op, logic [15:0] target, logic dir,
                                           logic [15:0] load_value);
        cmd_item_t c;
        c.command         = op;
        c.target_position = target;
        c.forward         = dir;
        c.new_position    = load_value;
        return c;
    endfunction

    function automatic cmd_item_t noisy_cmd(logic [1:0] op);
        return make_cmd(op, 16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)),
                        16'($urandom_range(0, 65535)));
    endfunction

    task automatic send_command(cmd_item_t c);
        cmd_valid <= 1'b1;
        cmd_item  <= c;
        do
            @(posedge clk);
        while (cmd_stall);
        motion.note_command(c);
    endtask

    task automatic pause_sender(int n);
        if (n > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // Sends one item; when the burst runs out, starts a new one, with a random gap if sender_gaps is set.
    task automatic issue(cmd_item_t c);
        send_command(c);
        items_issued++;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            if (sender_gaps)
                pause_sender($urandom_range(1, 6));
        end
        else
            burst_left--;
    endtask

    task automatic wait_until_drained();
        cmd_valid <= 1'b0;
        while (motion.pending.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_register(logic [CFG_INDEX_BITS-1:0] idx, logic [TABLE_BITS-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
        motion.write_reg(idx, value);
    endtask

    task automatic configure(logic [TABLE_BITS-1:0] coil_table, logic hold_idle);
        wait_until_drained();
        write_register(CFG_PHASE_TABLE, coil_table);
        write_register(CFG_TEST_MODE, {{(TABLE_BITS-1){1'b0}}, hold_idle});
    endtask

    // Mostly moves (usually a load, then start and about enough ticks to arrive), some noise.
    task automatic random_traffic(int budget, bit with_hold);
        int          stop_at;
        int          d;
        int          ticks;
        int          cut;
        logic [15:0] p;
        logic [15:0] target;
        logic        dir;
        stop_at = items_issued + budget;
        while (items_issued < stop_at)
        begin
            if (with_hold && items_issued >= stop_at - budget / 2)
            begin
                with_hold    = 1'b0;
                hold_toggle <= ~hold_toggle;
            end
            if ($urandom_range(0, 9) < 7)
            begin
                case ($urandom_range(0, 7))
                    0:       p = 16'($urandom_range(0, 8));
                    1:       p = 16'($urandom_range(65527, 65535));
                    default: p = 16'($urandom_range(0, 65535));
                endcase
                d   = $urandom_range(0, 12);
                dir = 1'($urandom_range(0, 1));
                if (dir)
                    target = p + d[15:0];
                else
                    target = (p >= d) ? p - d[15:0] : 16'd0;
                if ($urandom_range(0, 5) != 0)
                    issue(make_cmd(CMD_LOAD, 16'($urandom_range(0, 65535)),
                                   1'($urandom_range(0, 1)), p));
                issue(make_cmd(CMD_START, target, dir, 16'($urandom_range(0, 65535))));
                ticks = d + $urandom_range(0, 3);
                cut   = ($urandom_range(0, 5) == 0) ? $urandom_range(0, ticks) : -1;
                for (int i = 0; i < ticks; i++)
                begin
                    if (i == cut)
                        issue(make_cmd(CMD_LOAD, 16'($urandom_range(0, 65535)),
                                       1'($urandom_range(0, 1)),
                                       16'(target + $urandom_range(0, 3))));
                    issue(noisy_cmd(CMD_TICK));
                end
            end
            else
            begin
                repeat ($urandom_range(1, 4))
                    issue(noisy_cmd(2'($urandom_range(0, 3))));
            end
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        configure(64'h8877_6655_4433_2211, 1'b0);
        sender_gaps = 1'b0;
        issue(make_cmd(CMD_TICK, 16'hFFFF, 1'b1, 16'hFFFF));
        issue(make_cmd(CMD_UNUSED, 16'hFFFF, 1'b1, 16'hFFFF));
        // forward across the top of the range
        issue(make_cmd(CMD_LOAD, 16'h0000, 1'b0, 16'hFFFF));
        issue(make_cmd(CMD_START, 16'h0001, 1'b1, 16'h0000));
        repeat (3) issue(make_cmd(CMD_TICK, 16'h0000, 1'b0, 16'h0000));
        // reverse stuck at zero, then a load while moving
        issue(make_cmd(CMD_LOAD, 16'hFFFF, 1'b1, 16'h0000));
        issue(make_cmd(CMD_START, 16'h0002, 1'b0, 16'hFFFF));
        repeat (2) issue(make_cmd(CMD_TICK, 16'hFFFF, 1'b1, 16'hFFFF));
        issue(make_cmd(CMD_LOAD, 16'h0000, 1'b0, 16'h0005));
        repeat (4) issue(make_cmd(CMD_TICK, 16'h0000, 1'b0, 16'h0000));
        issue(make_cmd(CMD_START, 16'hFFFF, 1'b1, 16'h0000));
        issue(make_cmd(CMD_TICK, 16'h0000, 1'b0, 16'h0000));
        // reverse down to a goal of zero
        issue(make_cmd(CMD_START, 16'h0000, 1'b0, 16'hFFFF));
        issue(make_cmd(CMD_LOAD, 16'hFFFF, 1'b1, 16'h0002));
        repeat (3) issue(make_cmd(CMD_TICK, 16'hFFFF, 1'b1, 16'hFFFF));
        issue(make_cmd(CMD_TICK, 16'h0000, 1'b0, 16'h0000));

        sender_gaps = 1'b1;
        configure(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        random_traffic(160, 1'b0);
        configure(64'h0000_0000_0000_0000, 1'b1);
        random_traffic(160, 1'b0);
        configure({$urandom, $urandom}, 1'b1);
        sender_gaps = 1'b0;
        random_traffic(160, 1'b1);
        sender_gaps = 1'b1;
        configure(64'h0908_0C04_0602_0301, 1'b0);
        random_traffic(160, 1'b0);
        configure({$urandom, $urandom}, 1'b0);
        random_traffic(150, 1'b0);
        configure(64'h8000_0000_0000_0001, 1'b1);
        random_traffic(150, 1'b0);

        wait_until_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (motion.pending.size() != 0)
            motion.report($sformatf("%0d results never arrived", motion.pending.size()));
        if (motion.fails == 0)
            $display("stepper_half_step_positioner_unit test passed");
        else
            $display("stepper_half_step_positioner_unit test failed");
        $finish;
    end

endmodule
